### design/mfc_pkg.sv
package mfc_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 5;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_EXP_WIDTH = 2'd0,
    CFG_MAN_WIDTH = 2'd1,
    CFG_ROUND_MODE = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    RND_NEAREST_EVEN = 3'd0,
    RND_NEAREST_AWAY = 3'd1,
    RND_TRUNCATE = 3'd2,
    RND_UP = 3'd3,
    RND_DOWN = 3'd4
  } round_mode_e;

  typedef enum logic {
    REQ_ENCODE = 1'b0,
    REQ_DECODE = 1'b1
  } req_type_e;

  typedef struct packed {
    logic [3:0] ew;
    logic [4:0] mw;
    logic [2:0] rm;
  } cfg_t;

  localparam logic [63:0] QuietNan = 64'h7FF8000000000000;

endpackage

### design/mfc_cfg_regs.sv
module mfc_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mfc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [mfc_pkg::CfgDataW-1:0]     cfg_data_i,
  output mfc_pkg::cfg_t                    cfg_o
);

  logic [3:0] ew_q;
  logic [4:0] mw_q;
  logic [2:0] rm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ew_q <= 4'd8;
      mw_q <= 5'd23;
      rm_q <= mfc_pkg::RND_NEAREST_EVEN;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mfc_pkg::CFG_EXP_WIDTH:  ew_q <= cfg_data_i[3:0];
        mfc_pkg::CFG_MAN_WIDTH:  mw_q <= cfg_data_i;
        mfc_pkg::CFG_ROUND_MODE: rm_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // Out-of-range widths saturate into the supported range.
  always_comb begin
    cfg_o.ew = (ew_q < 4'd2) ? 4'd2 : ((ew_q > 4'd8) ? 4'd8 : ew_q);
    cfg_o.mw = (mw_q < 5'd1) ? 5'd1 : ((mw_q > 5'd23) ? 5'd23 : mw_q);
    cfg_o.rm = rm_q;
  end

endmodule

### design/mfc_convert.sv
module mfc_convert (
  input  mfc_pkg::cfg_t  cfg_i,
  input  logic           req_type_i,
  input  logic [63:0]    op_i,
  output logic [63:0]    result_o,
  output logic           inexact_o
);

  logic [3:0]  ew;
  logic [4:0]  mw;
  logic [8:0]  bias;
  logic [8:0]  emax;
  logic [5:0]  sh;
  // Encode.
  logic        neg;
  logic [10:0] e;
  logic [51:0] f;
  logic [62:0] mag;
  logic [62:0] maxbits;
  logic [11:0] stored;
  logic [51:0] q;
  logic [51:0] rest;
  logic [51:0] half;
  logic [51:0] lowmask;
  logic        up;
  logic [52:0] qr;
  logic [8:0]  st_fin;
  logic [63:0] enc;
  logic        enc_inx;
  logic [8:0]  enc_ex;
  logic [22:0] enc_man;
  logic        enc_neg;
  // Decode.
  logic        dsgn;
  logic [8:0]  dex;
  logic [22:0] dman;
  logic [4:0]  p;
  logic [22:0] dfrac;
  logic [10:0] be;
  logic [63:0] dec;

  always_comb begin
    ew = cfg_i.ew;
    mw = cfg_i.mw;
    bias = (9'd1 << (ew - 4'd1)) - 9'd1;
    emax = (9'd1 << ew) - 9'd1;
    sh = 6'd52 - {1'b0, mw};
    lowmask = (52'd1 << sh) - 52'd1;

    neg = op_i[63];
    e = op_i[62:52];
    f = op_i[51:0];
    mag = op_i[62:0];
    maxbits = {(11'(emax) - 11'd2 - 11'(bias) + 11'd1024), 52'd0}
            | 63'({~lowmask});
    stored = {1'b0, e} - 12'd1023 + 12'(bias);
    q = f >> sh;
    rest = f & lowmask;
    half = 52'd1 << (sh - 6'd1);
    up = 1'b0;
    if (rest != 52'd0) begin
      case (cfg_i.rm)
        mfc_pkg::RND_NEAREST_EVEN: up = (rest > half) || (rest == half && q[0]);
        mfc_pkg::RND_NEAREST_AWAY: up = rest >= half;
        mfc_pkg::RND_UP:           up = !neg;
        mfc_pkg::RND_DOWN:         up = neg;
        default:                   up = 1'b0;
      endcase
    end
    qr = {1'b0, q} + 53'(up);
    st_fin = stored[8:0];
    if (qr[mw]) begin
      qr = 53'd0;
      st_fin = stored[8:0] + 9'd1;
    end

    enc_neg = neg;
    enc_inx = 1'b0;
    enc_ex = st_fin;
    enc_man = qr[22:0];
    if (e == 11'h7FF) begin
      enc_ex = emax;
      enc_man = (f != 52'd0) ? 23'd1 : 23'd0;
      if (f != 52'd0) enc_neg = 1'b0;
    end else if (mag == 63'd0) begin
      enc_ex = 9'd0;
      enc_man = 23'd0;
    end else if (mag > maxbits) begin
      enc_inx = 1'b1;
      enc_ex = emax;
      enc_man = 23'd0;
    end else if (e == 11'd0 || $signed(stored) <= 0) begin
      enc_inx = 1'b1;
      enc_ex = 9'd0;
      enc_man = 23'd0;
    end else begin
      // A rounding carry that reaches the top exponent was already excluded by maxbits.
      enc_inx = (rest != 52'd0);
    end
    enc = ((64'(enc_ex) & 64'(emax)) << mw)
        | (64'(enc_man) & ((64'd1 << mw) - 64'd1));
    if (enc_neg) enc = enc | (64'd1 << (5'(ew) + mw));

    dsgn = op_i[5'(ew) + mw];
    dex = 9'(op_i >> mw) & emax;
    dman = 23'(op_i) & 23'((24'd1 << mw) - 24'd1);
    p = 5'd0;
    for (int i = 1; i < 23; i++) begin
      if (dman[i]) p = 5'(i);
    end
    dfrac = dman & 23'((24'd1 << p) - 24'd1);
    be = 11'd0;
    if (dex == emax) begin
      dec = (dman != 23'd0) ? mfc_pkg::QuietNan : {dsgn, 63'h7FF0000000000000};
    end else if (dex == 9'd0) begin
      be = 11'(p) + 11'd1024 - 11'(bias) - 11'(mw);
      dec = (dman == 23'd0) ? {dsgn, 63'd0}
          : {dsgn, be, 52'(dfrac) << (6'd52 - 6'(p))};
    end else begin
      be = 11'(dex) - 11'(bias) + 11'd1023;
      dec = {dsgn, be, 52'(dman) << sh};
    end

    result_o = (req_type_i == mfc_pkg::REQ_DECODE) ? dec : enc;
    inexact_o = (req_type_i == mfc_pkg::REQ_DECODE) ? 1'b0 : enc_inx;
  end

endmodule

### design/minifloat_format_converter.sv
// Minifloat format converter: binary64 <-> sign/exponent/mantissa minifloat.
// Input stream s_axis_*: one word per request; tuser carries req_type
// (0 encode, 1 decode), tdata carries operand_bits.
// Output stream m_axis_*: one word per request; tdata carries result_bits,
// tuser carries inexact.
// Configuration: cfg_we_i/cfg_idx_i/cfg_data_i write exponent_width (0),
// mantissa_width (1) and round_mode (2); write only while idle.
// The path is an input register, then single-pass conversion logic
// feeding the output register. Throughput is one word per cycle when
// the receiver does not stall.
// Reset clears both valid flags and restores widths 8/23 and nearest-even.
// When the receiver stalls, the output register holds its word and the
// input register takes a new word only if it is empty or moving on.
module minifloat_format_converter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mfc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mfc_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [63:0]                  s_axis_tdata,  // operand_bits
  input  logic                         s_axis_tuser,  // req_type
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [63:0]                  m_axis_tdata,  // result_bits
  output logic                         m_axis_tuser   // inexact
);

  mfc_pkg::cfg_t cfg;
  logic        in_vld_q, out_vld_q;
  logic        req_q;
  logic [63:0] op_q;
  logic [63:0] res_d, res_q;
  logic        inx_d, inx_q;
  logic        out_ready;

  mfc_cfg_regs u_cfg (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .cfg_o(cfg)
  );

  mfc_convert u_conv (
    .cfg_i(cfg), .req_type_i(req_q), .op_i(op_q),
    .result_o(res_d), .inexact_o(inx_d)
  );

  assign out_ready = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_vld_q <= s_axis_tvalid;
      if (out_ready) out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      op_q <= s_axis_tdata;
      req_q <= s_axis_tuser;
    end
    if (out_ready && in_vld_q) begin
      res_q <= res_d;
      inx_q <= inx_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata = res_q;
  assign m_axis_tuser = inx_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("output word changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !out_ready) |-> !s_axis_tready)
    else $error("input taken while pipeline full");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && out_ready) |=> m_axis_tvalid)
    else $error("word lost between stages");

endmodule

### dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  class conversion_scoreboard;
    logic [3:0] exp_w;
    logic [4:0] man_w;
    logic [2:0] rnd;
    logic [64:0] pending[$];
    int unsigned errors;

    function new();
      exp_w = 4'd8;
      man_w = 5'd23;
      rnd = mfc_pkg::RND_NEAREST_EVEN;
      errors = 0;
    endfunction

    function automatic logic [63:0] pack_mini(int unsigned ew, int unsigned mw, bit neg,
                                              longint unsigned ex, longint unsigned man);
      logic [63:0] r;
      r = ((ex & ((64'd1 << ew) - 1)) << mw) | (man & ((64'd1 << mw) - 1));
      if (neg) r |= 64'd1 << (ew + mw);
      return r;
    endfunction

    // Returns {inexact, result_bits} for one request.
    function automatic logic [64:0] convert(mfc_pkg::req_type_e kind, logic [63:0] b);
      int unsigned ew, mw, sh, p;
      int bias, emax, stored, be;
      bit neg, up;
      logic [63:0] e, f, mag, maxbits, q, rest, half, sgn, ex, man;
      ew = (exp_w < 2) ? 2 : (exp_w > 8) ? 8 : exp_w;
      mw = (man_w < 1) ? 1 : (man_w > 23) ? 23 : man_w;
      bias = (1 << (ew - 1)) - 1;
      emax = (1 << ew) - 1;
      up = 0;
      if (kind == mfc_pkg::REQ_ENCODE) begin
        neg = b[63];
        e = (b >> 52) & 64'h7FF;
        f = b & ((64'd1 << 52) - 1);
        mag = {1'b0, b[62:0]};
        if (e == 64'h7FF) begin
          if (f != 0) return {1'b0, pack_mini(ew, mw, 0, emax, 1)};
          return {1'b0, pack_mini(ew, mw, neg, emax, 0)};
        end
        if (mag == 0) return {1'b0, pack_mini(ew, mw, neg, 0, 0)};
        maxbits = (64'(emax - 1 - bias + 1023) << 52) | (((64'd1 << mw) - 1) << (52 - mw));
        if (mag > maxbits) return {1'b1, pack_mini(ew, mw, neg, emax, 0)};
        if (e == 0) return {1'b1, pack_mini(ew, mw, neg, 0, 0)};
        stored = int'(e) - 1023 + bias;
        if (stored <= 0) return {1'b1, pack_mini(ew, mw, neg, 0, 0)};
        if (stored >= emax) return {1'b1, pack_mini(ew, mw, neg, emax, 0)};
        sh = 52 - mw;
        q = f >> sh;
        rest = f & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
        if (rest != 0) begin
          case (rnd)
            mfc_pkg::RND_NEAREST_EVEN: up = (rest > half) || (rest == half && q[0]);
            mfc_pkg::RND_NEAREST_AWAY: up = rest >= half;
            mfc_pkg::RND_UP:           up = !neg;
            mfc_pkg::RND_DOWN:         up = neg;
            default:                   up = 0;
          endcase
        end
        if (up) q++;
        if (q >= (64'd1 << mw)) begin
          q = 0;
          stored++;
          if (stored >= emax) return {1'b1, pack_mini(ew, mw, neg, emax, 0)};
        end
        return {rest != 0, pack_mini(ew, mw, neg, stored, q)};
      end
      sgn = 64'((b >> (ew + mw)) & 1) << 63;
      ex = (b >> mw) & emax;
      man = b & ((64'd1 << mw) - 1);
      if (ex == emax) begin
        if (man != 0) return {1'b0, mfc_pkg::QuietNan};
        return {1'b0, sgn | 64'h7FF0000000000000};
      end
      if (ex == 0) begin
        if (man == 0) return {1'b0, sgn};
        p = 0;
        while (p < 63 && (man >> (p + 1)) != 0) p++;
        be = int'(p) + 1 - bias - int'(mw) + 1023;
        return {1'b0, sgn | (64'(be) << 52) | ((man & ((64'd1 << p) - 1)) << (52 - p))};
      end
      be = int'(ex) - bias + 1023;
      return {1'b0, sgn | (64'(be) << 52) | (man << (52 - mw))};
    endfunction

    function void note_request(logic kind, logic [63:0] operand);
      pending.push_back(convert(mfc_pkg::req_type_e'(kind), operand));
    endfunction

    function void check_result(logic [63:0] data, logic flag);
      logic [64:0] want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result word %h inexact %b", data, flag);
        return;
      end
      want = pending.pop_front();
      if (want[63:0] !== data || want[64] !== flag) begin
        errors++;
        if (errors <= 10)
          $display("Mismatch: expected %h inexact %b, got %h inexact %b",
                   want[63:0], want[64], data, flag);
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [mfc_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [mfc_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic s_axis_tuser = 0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [63:0] m_axis_tdata;
  logic m_axis_tuser;

  conversion_scoreboard sb = new();
  bit quiet_gaps = 0;
  bit long_hold = 0;
  longint unsigned cycles = 0;

  always #10 clk_i = ~clk_i;

  minifloat_format_converter i_dut (.*);

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);

  // Receiver: random stall per word, plus one long hold-off on request.
  initial begin
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        m_axis_tready <= 0;
        repeat (300) @(negedge clk_i);
        long_hold = 0;
      end
      gap = quiet_gaps ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
        m_axis_tready <= 0;
        repeat (gap - 1) @(negedge clk_i);
        @(negedge clk_i);
      end
      m_axis_tready <= 1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  task automatic send_word(logic kind, logic [63:0] operand);
    int unsigned gap;
    gap = quiet_gaps ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= kind;
    s_axis_tdata <= operand;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_request(kind, operand);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(mfc_pkg::cfg_idx_e idx, logic [mfc_pkg::CfgDataW-1:0] value);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 0;
    case (idx)
      mfc_pkg::CFG_EXP_WIDTH: sb.exp_w = value[3:0];
      mfc_pkg::CFG_MAN_WIDTH: sb.man_w = value;
      default:                sb.rnd = value[2:0];
    endcase
  endtask

  // Mostly values near the representable range, so rounding is exercised.
  function automatic logic [63:0] random_operand(logic kind);
    logic [63:0] v;
    int unsigned ew;
    v = {$urandom, $urandom};
    if (kind == mfc_pkg::REQ_DECODE || $urandom_range(0, 5) == 0) return v;
    ew = (sb.exp_w < 2) ? 2 : (sb.exp_w > 8) ? 8 : sb.exp_w;
    v[62:52] = 11'(1023 + int'($urandom_range(0, 2 << ew)) - (1 << ew));
    if ($urandom_range(0, 3) == 0) v[28:0] = $urandom_range(0, 1) ? '1 : '0;
    return v;
  endfunction

  initial begin
    logic [63:0] edge_ops[$];
    logic kind;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);
    edge_ops = '{64'h0, 64'h8000000000000000, 64'h7FF0000000000000, 64'hFFF0000000000000,
                 64'h7FF8000000000001, 64'hFFFFFFFFFFFFFFFF, 64'h0000000000000001,
                 64'h47EFFFFFE0000000, 64'h47EFFFFFF0000000, 64'h47F0000000000000,
                 64'h3810000000000000, 64'h380FFFFFFFFFFFFF, 64'h3FF0000010000000,
                 64'h3FF0000030000000, 64'hBFF0000010000001, 64'h3FFFFFFFFFFFFFFF};
    foreach (edge_ops[i]) send_word(mfc_pkg::REQ_ENCODE, edge_ops[i]);
    foreach (edge_ops[i]) send_word(mfc_pkg::REQ_DECODE, edge_ops[i]);
    drain();
    for (int phase = 0; phase < 12; phase++) begin
      case (phase)
        0: begin
          write_reg(mfc_pkg::CFG_EXP_WIDTH, 5'd2);
          write_reg(mfc_pkg::CFG_MAN_WIDTH, 5'd1);
        end
        1: begin
          write_reg(mfc_pkg::CFG_EXP_WIDTH, 5'd0);
          write_reg(mfc_pkg::CFG_MAN_WIDTH, 5'd0);
        end
        2: begin
          write_reg(mfc_pkg::CFG_EXP_WIDTH, 5'd15);
          write_reg(mfc_pkg::CFG_MAN_WIDTH, 5'd31);
        end
        default: begin
          write_reg(mfc_pkg::CFG_EXP_WIDTH, 5'($urandom_range(0, 15)));
          write_reg(mfc_pkg::CFG_MAN_WIDTH, 5'($urandom_range(0, 31)));
        end
      endcase
      write_reg(mfc_pkg::CFG_ROUND_MODE, 5'(phase % 8));
      quiet_gaps = (phase % 4 == 1);
      if (phase == 3) long_hold = 1;
      repeat (170) begin
        kind = 1'($urandom_range(0, 1));
        send_word(kind, random_operand(kind));
      end
      drain();
    end
    if (sb.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
